>>> rtl/pbu_pkg.sv
// Shared constants, types and fixed-point helpers for the premultiplied blend unit.
package pbu_pkg;

  localparam int FRAC_BITS = 15;
  localparam int PIX_W = 16;
  localparam int MODE_W = 3;
  localparam int unsigned ONE = 1 << FRAC_BITS;

  // Weight 1-x ranges over 0..ONE.
  localparam int WGT_W = FRAC_BITS + 1;
  localparam int MUL_W = (WGT_W > PIX_W) ? WGT_W : PIX_W;
  // A truncated product of two operands holds at most this many bits.
  localparam int PROD_W = (2 * PIX_W - FRAC_BITS > PIX_W) ? 2 * PIX_W - FRAC_BITS : PIX_W + 1;
  // Signed sum of up to three products.
  localparam int SUM_W = PROD_W + 3;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLUS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCREEN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIN = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MAX = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MIX = 3'd6;

  typedef struct packed {
    logic adv2;
    logic adv3;
  } pipe_ctl_t;

  function automatic logic [PROD_W-1:0] fx_mul(input logic [MUL_W-1:0] a,
                                               input logic [MUL_W-1:0] b);
    logic [2*MUL_W-1:0] full;
    full = a * b;
    return full[FRAC_BITS +: PROD_W];
  endfunction

  function automatic logic [WGT_W-1:0] fx_inv(input logic [PIX_W-1:0] x);
    logic [MUL_W-1:0] ext;
    logic [MUL_W-1:0] one_m;
    ext = MUL_W'(x);
    one_m = MUL_W'(ONE);
    if (ext >= one_m) begin
      return '0;
    end
    return WGT_W'(one_m - ext);
  endfunction

  function automatic logic [PIX_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] top_v;
    top_v = signed'(SUM_W'({PIX_W{1'b1}}));
    if (v < 0) begin
      return '0;
    end
    if (v > top_v) begin
      return {PIX_W{1'b1}};
    end
    return v[PIX_W-1:0];
  endfunction

endpackage

>>> rtl/pbu_channel.sv
// One color channel of the blend pipeline: product stage and mode-select stage.
module pbu_channel (
  input  logic                          clk,
  input  pbu_pkg::pipe_ctl_t            ctl,
  input  logic [pbu_pkg::MODE_W-1:0]    mode,
  input  logic [pbu_pkg::PIX_W-1:0]     s,
  input  logic [pbu_pkg::PIX_W-1:0]     d,
  input  logic [pbu_pkg::PIX_W-1:0]     as,
  input  logic [pbu_pkg::PIX_W-1:0]     ab,
  input  logic [pbu_pkg::WGT_W-1:0]     sonly,
  input  logic [pbu_pkg::WGT_W-1:0]     bonly,
  output logic [pbu_pkg::PIX_W-1:0]     result
);
  import pbu_pkg::*;

  logic [MODE_W-1:0] mode2;
  logic [PIX_W-1:0]  s2;
  logic [PIX_W-1:0]  d2;
  logic [PROD_W-1:0] p_sd;
  logic [PROD_W-1:0] p_ss;
  logic [PROD_W-1:0] p_db;
  logic [PROD_W-1:0] p_abs;
  logic [PROD_W-1:0] p_asd;

  logic [PROD_W-1:0]       pick;
  logic signed [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      mode2 <= mode;
      s2    <= s;
      d2    <= d;
      p_sd  <= fx_mul(MUL_W'(s), MUL_W'(d));
      p_ss  <= fx_mul(MUL_W'(s), MUL_W'(sonly));
      p_db  <= fx_mul(MUL_W'(d), MUL_W'(bonly));
      p_abs <= fx_mul(MUL_W'(ab), MUL_W'(s));
      p_asd <= fx_mul(MUL_W'(as), MUL_W'(d));
    end
  end

  always_comb begin
    pick = (p_abs < p_asd) ? p_abs : p_asd;
    if (mode2 == MODE_MAX) begin
      pick = (p_abs > p_asd) ? p_abs : p_asd;
    end
    case (mode2)
      MODE_PLUS: begin
        sum = signed'(SUM_W'(s2)) + signed'(SUM_W'(d2));
      end
      MODE_MULTIPLY: begin
        sum = signed'(SUM_W'(p_sd)) + signed'(SUM_W'(p_ss)) + signed'(SUM_W'(p_db));
      end
      MODE_SCREEN: begin
        sum = signed'(SUM_W'(s2)) + signed'(SUM_W'(d2)) - signed'(SUM_W'(p_sd));
      end
      MODE_MIN, MODE_MAX: begin
        sum = signed'(SUM_W'(pick)) + signed'(SUM_W'(p_ss)) + signed'(SUM_W'(p_db));
      end
      MODE_NORMAL, MODE_MIX: begin
        sum = signed'(SUM_W'(s2)) + signed'(SUM_W'(p_db));
      end
      default: begin
        sum = signed'(SUM_W'(s2)) + signed'(SUM_W'(p_db));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      result <= sat16(sum);
    end
  end

endmodule

>>> rtl/premultiplied_blend_unit.sv
// Top level of the premultiplied blend unit: input stage, alpha path and pipeline control.
//
// Channel   Dir  Width  Contents
// s_axis    in   128    source r,g,b,a then backdrop r,g,b,a, 16 bits each
// m_axis    out  64     blended r,g,b and union alpha, 16 bits each
// cfg       in   3      blend mode register write
//
// One pixel is accepted per cycle while s_axis_tready is high; its result is valid once it reaches the output stage.
// The pipeline has three register stages: weights, products, then mode select and saturate.
// Each stage moves forward when the next one is empty or advancing, so bubbles are squeezed
// out under a stall. The blend mode is sampled when a pixel is accepted and travels with it.
// Reset clears the valid bits and sets the mode to normal.
module premultiplied_blend_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [pbu_pkg::MODE_W-1:0] cfg_wdata
);
  import pbu_pkg::*;

  logic [MODE_W-1:0] blend_mode;

  logic v1;
  logic v2;
  logic v3;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  pipe_ctl_t ctl;

  logic [MODE_W-1:0] mode1;
  logic [PIX_W-1:0]  src1 [3];
  logic [PIX_W-1:0]  dst1 [3];
  logic [PIX_W-1:0]  as1;
  logic [PIX_W-1:0]  ab1;
  logic [WGT_W-1:0]  sonly1;
  logic [WGT_W-1:0]  bonly1;

  logic [PIX_W-1:0]  as2;
  logic [PROD_W-1:0] p_alpha;
  logic [PIX_W-1:0]  alpha3;
  logic [PIX_W-1:0]  color3 [3];

  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign ctl.adv2 = rdy2;
  assign ctl.adv3 = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_NORMAL;
    end else if (cfg_we) begin
      blend_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1   <= blend_mode;
      src1[0] <= s_axis_tdata[15:0];
      src1[1] <= s_axis_tdata[31:16];
      src1[2] <= s_axis_tdata[47:32];
      as1     <= s_axis_tdata[63:48];
      dst1[0] <= s_axis_tdata[79:64];
      dst1[1] <= s_axis_tdata[95:80];
      dst1[2] <= s_axis_tdata[111:96];
      ab1     <= s_axis_tdata[127:112];
      sonly1  <= fx_inv(s_axis_tdata[127:112]);
      bonly1  <= fx_inv(s_axis_tdata[63:48]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      as2     <= as1;
      p_alpha <= fx_mul(MUL_W'(ab1), MUL_W'(bonly1));
    end
    if (rdy3) begin
      alpha3 <= sat16(signed'(SUM_W'(as2)) + signed'(SUM_W'(p_alpha)));
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_chan
    pbu_channel u_chan (
      .clk    (clk),
      .ctl    (ctl),
      .mode   (mode1),
      .s      (src1[i]),
      .d      (dst1[i]),
      .as     (as1),
      .ab     (ab1),
      .sonly  (sonly1),
      .bonly  (bonly1),
      .result (color3[i])
    );
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {alpha3, color3[2], color3[1], color3[0]};

  a_stage1_moves: assert property (@(posedge clk) disable iff (rst)
    v1 && rdy2 |=> v2)
    else $error("stage one item was not moved into stage two");

  a_stage2_moves: assert property (@(posedge clk) disable iff (rst)
    v2 && rdy3 |=> v3)
    else $error("stage two item was not moved into stage three");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> v1 && v2 && v3 && !m_axis_tready)
    else $error("input stalled while the pipeline had room");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy3 |=> v2 && $stable(p_alpha) && $stable(as2))
    else $error("stage two request changed while stalled");

endmodule

>>> sim/premultiplied_blend_unit_test.sv
// Self-checking testbench for the premultiplied blend unit, covering every blend mode code.
module premultiplied_blend_unit_test;
  import pbu_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS = 80;

  typedef logic [3:0][PIX_W-1:0] layer_t;

  // Index 0 is red, then green, blue and alpha; src occupies the low 64 bits.
  typedef struct packed {
    layer_t dst;
    layer_t src;
  } pixel_pair_t;

  // out_red, out_green, out_blue, out_alpha from the lowest bits up.
  typedef logic [3:0][PIX_W-1:0] blend_result_t;

  class blend_scoreboard;
    logic [MODE_W-1:0] blend_mode;
    blend_result_t expected_pixels[$];
    int checked;
    int mismatches;
    int unexpected;

    function new();
      blend_mode = MODE_NORMAL;
      checked = 0;
      mismatches = 0;
      unexpected = 0;
    endfunction

    function longint unsigned scaled_product(longint unsigned a, longint unsigned b);
      return (a * b) >> FRAC_BITS;
    endfunction

    function longint unsigned remaining_coverage(longint unsigned x);
      return (x >= ONE) ? 0 : ONE - x;
    endfunction

    function logic [PIX_W-1:0] clamp_pixel(longint v);
      if (v < 0) begin
        return '0;
      end
      if (v > 65535) begin
        return 16'hFFFF;
      end
      return v[PIX_W-1:0];
    endfunction

    function blend_result_t blend_pixel(pixel_pair_t px);
      longint unsigned src_cov, dst_cov, src_only, dst_only, s, d, a, b;
      longint total;
      blend_result_t res;
      src_cov = px.src[3];
      dst_cov = px.dst[3];
      src_only = remaining_coverage(dst_cov);
      dst_only = remaining_coverage(src_cov);
      for (int c = 0; c < 3; c++) begin
        s = px.src[c];
        d = px.dst[c];
        case (blend_mode)
          MODE_PLUS: begin
            total = s + d;
          end
          MODE_MULTIPLY: begin
            total = scaled_product(s, d) + scaled_product(s, src_only)
                  + scaled_product(d, dst_only);
          end
          MODE_SCREEN: begin
            total = longint'(s + d) - longint'(scaled_product(s, d));
          end
          MODE_MIN, MODE_MAX: begin
            a = scaled_product(dst_cov, s);
            b = scaled_product(src_cov, d);
            if (blend_mode == MODE_MIN) begin
              a = (a < b) ? a : b;
            end else begin
              a = (a > b) ? a : b;
            end
            total = a + scaled_product(s, src_only) + scaled_product(d, dst_only);
          end
          default: begin
            total = s + scaled_product(d, dst_only);
          end
        endcase
        res[c] = clamp_pixel(total);
      end
      res[3] = clamp_pixel(src_cov + scaled_product(dst_cov, dst_only));
      return res;
    endfunction

    function void note_request(pixel_pair_t px);
      expected_pixels.push_back(blend_pixel(px));
    endfunction

    function void check_result(blend_result_t got);
      blend_result_t want;
      bit bad;
      if (expected_pixels.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) begin
          $display("Result %h arrived with no request outstanding", got);
        end
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      bad = 0;
      for (int c = 0; c < 4; c++) begin
        if (got[c] !== want[c]) begin
          bad = 1;
        end
      end
      if (bad) begin
        mismatches++;
        if (mismatches + unexpected <= 10) begin
          $display("Mismatch in mode %0d: expected r=%0d g=%0d b=%0d a=%0d,",
                   blend_mode, want[0], want[1], want[2], want[3]);
          $display("  got r=%0d g=%0d b=%0d a=%0d",
                   got[0], got[1], got[2], got[3]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = '0;

  blend_scoreboard sb;
  bit quiet_run = 0;
  bit hold_output = 0;
  int idle_cycles = 0;
  pixel_pair_t directed_pixels[3];

  premultiplied_blend_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timed out with %0d results outstanding", sb.expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic layer_t random_layer();
    layer_t layer;
    int unsigned cov;
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      case ($urandom_range(0, 3))
        0: begin
          cov = 0;
        end
        1: begin
          cov = ONE;
        end
        default: begin
          cov = $urandom_range(0, ONE);
        end
      endcase
      layer[3] = PIX_W'(cov);
      for (int c = 0; c < 3; c++) begin
        layer[c] = PIX_W'($urandom_range(0, cov));
      end
    end else if (kind < 17) begin
      for (int c = 0; c < 4; c++) begin
        layer[c] = PIX_W'($urandom_range(0, ONE));
      end
    end else begin
      for (int c = 0; c < 4; c++) begin
        layer[c] = PIX_W'($urandom_range(0, 16'hFFFF));
      end
    end
    return layer;
  endfunction

  task automatic send_pixel(input pixel_pair_t px);
    if (!quiet_run && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.blend_mode = mode;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    pixel_pair_t px;
    sb = new();
    directed_pixels[0].src = '{16'd0, 16'd0, 16'd0, 16'd0};
    directed_pixels[0].dst = '{PIX_W'(ONE), PIX_W'(ONE), PIX_W'(ONE), PIX_W'(ONE)};
    directed_pixels[1].src = '{PIX_W'(ONE), 16'd12345, 16'd0, PIX_W'(ONE)};
    directed_pixels[1].dst = '{16'd16384, 16'd0, 16'd16384, 16'd1000};
    directed_pixels[2].src = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    directed_pixels[2].dst = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first pass relies on the mode that reset leaves behind.
    for (int m = 0; m < 8; m++) begin
      if (m != 0) begin
        write_mode(MODE_W'(m));
      end
      foreach (directed_pixels[i]) begin
        send_pixel(directed_pixels[i]);
      end
      finish_phase();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet_run = (p == RANDOM_PHASES - 1);
      write_mode(MODE_W'((p + 7) % 8));
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (p == 1 && n == 10) begin
          hold_output = 1;
        end
        px.src = random_layer();
        px.dst = random_layer();
        send_pixel(px);
      end
      finish_phase();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d blended pixels over all eight mode codes, with random gaps",
             sb.checked);
    $display("on both sides and one long output stall that backed the pipeline up.");
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d unexpected results, %0d missing results",
               sb.mismatches, sb.unexpected, sb.expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
